// ----- rtl/core/tbn_pkg.sv -----
// tbn_pkg: shared types and constants of the tangent frame block.
// No dependencies; used by every file under rtl/core except tbn_xmul.

package tbn_pkg;

    // Fixed field widths
    localparam int OUT_W  = 16;   // unit vector component, Q1.14
    localparam int STAT_W = 2;

    // Fraction bits of a unit vector component; tied to OUT_W
    localparam int UNIT_FRAC_BITS = 14;

    // Normaliser widths: largest component scaled into [2^29, 2^30)
    localparam int NORM_W = 30;
    localparam int SQ_AW  = NORM_W + 1;        // signed operand of the squarer
    localparam int SUM_W  = 2 * NORM_W + 2;    // sum of three squares
    localparam int ROOT_W = NORM_W + 1;        // floor square root of the sum

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_ZERO_DET = 2'd1,
        STAT_ZERO_LEN = 2'd2
    } status_t;

    // Cross-difference operations a*b - c*d run on the serial multiplier
    typedef enum logic [3:0] {
        OP_DET = 4'd0,
        OP_TX  = 4'd1,
        OP_TY  = 4'd2,
        OP_TZ  = 4'd3,
        OP_BX  = 4'd4,
        OP_BY  = 4'd5,
        OP_BZ  = 4'd6,
        OP_NX  = 4'd7,
        OP_NY  = 4'd8,
        OP_NZ  = 4'd9
    } xop_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_XM_GO,
        S_XM_WAIT,
        S_CHECK,
        S_NM_LOAD,
        S_NM_SHIFT,
        S_SQ_GO,
        S_SQ_WAIT,
        S_SR_GO,
        S_SR_WAIT,
        S_DV_GO,
        S_DV_WAIT,
        S_FINISH
    } state_t;

endpackage

// ----- rtl/core/tbn_xmul.sv -----
// tbn_xmul: bit-serial signed a*b - c*d, one multiplier bit per cycle.
// Depends on nothing; instanced twice by triangle_tangent_bitangent.

module tbn_xmul #(
    parameter int AW = 17
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [AW-1:0]  a,
    input  logic signed [AW-1:0]  b,
    input  logic signed [AW-1:0]  c,
    input  logic signed [AW-1:0]  d,
    output logic                  done,
    output logic signed [2*AW:0]  result
);

    localparam int RW = 2 * AW + 1;
    localparam int CW = $clog2(AW);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CW-1:0]        cnt_reg;
    logic signed [AW-1:0] a_reg;
    logic signed [AW-1:0] c_reg;
    logic [AW-1:0]        b_reg;
    logic [AW-1:0]        d_reg;
    logic signed [RW-1:0] acc_reg;
    logic signed [RW-1:0] acc_next;
    logic signed [RW-1:0] ax;
    logic signed [RW-1:0] cx;
    logic signed [RW-1:0] t1;
    logic signed [RW-1:0] t2;
    logic                 msb_step;

    // Horner step from the multiplier MSB; the MSB carries negative weight
    always_comb
    begin
        ax       = {{(RW-AW){a_reg[AW-1]}}, a_reg};
        cx       = {{(RW-AW){c_reg[AW-1]}}, c_reg};
        msb_step = (cnt_reg == CW'(AW - 1));
        t1       = b_reg[AW-1] ? ax : '0;
        t2       = d_reg[AW-1] ? cx : '0;
        if (msb_step)
        begin
            t1 = -t1;
            t2 = -t2;
        end
        acc_next = (acc_reg <<< 1) + t1 - t2;
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(AW - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Operand shift registers and accumulator
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            c_reg   <= c;
            b_reg   <= b;
            d_reg   <= d;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= b_reg << 1;
            d_reg   <= d_reg << 1;
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

// ----- rtl/core/tbn_sqrt.sv -----
// tbn_sqrt: digit-by-digit floor square root, one root bit per cycle.
// Depends on tbn_pkg for the sum and root widths.

module tbn_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [tbn_pkg::SUM_W-1:0]    radicand,
    output logic                         done,
    output logic [tbn_pkg::ROOT_W-1:0]   root
);

    localparam int XW = tbn_pkg::SUM_W;
    localparam int RT = tbn_pkg::ROOT_W;
    localparam int MW = RT + 2;            // partial remainder
    localparam int CW = $clog2(RT);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [XW-1:0] x_reg;
    logic [MW-1:0] rem_reg;
    logic [RT-1:0] root_reg;
    logic [MW+1:0] rem2;
    logic [MW+1:0] trial;
    logic          fits;

    // Bring down two radicand bits, try root*4+1
    always_comb
    begin
        rem2  = {rem_reg, x_reg[XW-1 -: 2]};
        trial = (MW+2)'({root_reg, 2'b01});
        fits  = (rem2 >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(RT - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg <= x_reg << 2;
            if (fits)
            begin
                rem_reg  <= MW'(rem2 - trial);
                root_reg <= {root_reg[RT-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem2[MW-1:0];
                root_reg <= {root_reg[RT-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- rtl/core/tbn_div.sv -----
// tbn_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on tbn_pkg for the divisor and quotient widths.

module tbn_div #(
    parameter int NB = 45
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [NB-1:0]                    numer,
    input  logic [tbn_pkg::ROOT_W-1:0]       denom,
    output logic                             done,
    output logic [NB-tbn_pkg::NORM_W:0]      quot
);

    localparam int DW = tbn_pkg::ROOT_W;
    localparam int QW = NB - tbn_pkg::NORM_W + 1;
    localparam int CW = $clog2(NB);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NB-1:0] n_reg;
    logic [DW-1:0] d_reg;
    logic [DW-1:0] rem_reg;
    logic [QW-1:0] q_reg;
    logic [DW:0]   rem2;
    logic          fits;

    // Shift in the next numerator bit and try a subtract
    always_comb
    begin
        rem2 = {rem_reg, n_reg[NB-1]};
        fits = (rem2 >= {1'b0, d_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NB - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= numer;
            d_reg   <= denom;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            n_reg <= n_reg << 1;
            if (fits)
            begin
                rem_reg <= DW'(rem2 - {1'b0, d_reg});
                q_reg   <= {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem2[DW-1:0];
                q_reg   <= {q_reg[QW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ----- rtl/core/triangle_tangent_bitangent.sv -----
// triangle_tangent_bitangent: per-triangle unit tangent and bitangent.
// Depends on tbn_pkg, tbn_xmul, tbn_sqrt and tbn_div.
//
//  channel  | handshake      | payload
//  ---------+----------------+------------------------------------------------
//  vertex   | start, busy    | pos_x/y/z, tex_u/v, start_triangle
//  result   | done (strobe)  | tangent_x/y/z, bitangent_x/y/z, status
//
// A vertex transaction is taken when start is high and busy is low. The first
// two vertices of a triangle are stored. The third starts a sequence on the
// bit-serial units: ten cross differences on the serial multiplier, then,
// unless the triangle is degenerate, per vector a scaling shift, three
// squarings, the root and three divisions. done pulses one cycle; no stall.
// Reset clears the vertex count and the sequencer.

module triangle_tangent_bitangent #(
    parameter int COORD_WIDTH    = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [COORD_WIDTH-1:0]       pos_x,
    input  logic signed [COORD_WIDTH-1:0]       pos_y,
    input  logic signed [COORD_WIDTH-1:0]       pos_z,
    input  logic signed [COORD_WIDTH-1:0]       tex_u,
    input  logic signed [COORD_WIDTH-1:0]       tex_v,
    input  logic                                start_triangle,
    output logic                                done,
    output logic signed [tbn_pkg::OUT_W-1:0]    tangent_x,
    output logic signed [tbn_pkg::OUT_W-1:0]    tangent_y,
    output logic signed [tbn_pkg::OUT_W-1:0]    tangent_z,
    output logic signed [tbn_pkg::OUT_W-1:0]    bitangent_x,
    output logic signed [tbn_pkg::OUT_W-1:0]    bitangent_y,
    output logic signed [tbn_pkg::OUT_W-1:0]    bitangent_z,
    output logic [tbn_pkg::STAT_W-1:0]          status
);

    localparam int W   = COORD_WIDTH;
    localparam int F   = tbn_pkg::UNIT_FRAC_BITS;
    localparam int DW  = W + 1;                              // edge / UV delta
    localparam int RW  = 2 * DW + 1;                         // raw vector component
    localparam int SW  = (RW > tbn_pkg::NORM_W + 1) ? RW : tbn_pkg::NORM_W + 1;
    localparam int NB  = tbn_pkg::NORM_W + 1 + F;            // divider numerator
    localparam int QW  = F + 2;                              // quotient
    localparam int OW  = tbn_pkg::OUT_W;
    localparam int XW  = (QW > OW) ? QW : OW;
    localparam int NW  = tbn_pkg::NORM_W;

    // Sequencer and vertex count
    tbn_pkg::state_t state_reg, state_next;
    tbn_pkg::xop_t   op_reg, op_next;
    logic [1:0]      vcnt_reg, vcnt_next;
    logic            vec_reg, vec_next;
    logic [1:0]      comp_reg, comp_next;
    logic            done_reg, done_next;

    // Vertex store and deltas
    logic signed [W-1:0]  fpos_reg [3];
    logic signed [W-1:0]  spos_reg [3];
    logic signed [W-1:0]  fuv_reg  [2];
    logic signed [W-1:0]  suv_reg  [2];
    logic signed [DW-1:0] e1_reg   [3];
    logic signed [DW-1:0] e2_reg   [3];
    logic signed [DW-1:0] du1_reg, dv1_reg, du2_reg, dv2_reg;

    // Raw products
    logic                 det_zero_reg, det_neg_reg, nz_reg;
    logic signed [RW-1:0] tr_reg [3];
    logic signed [RW-1:0] br_reg [3];

    // Normaliser
    logic [SW-1:0]                 mag_reg  [3];
    logic                          negc_reg [3];
    logic [tbn_pkg::SUM_W-1:0]     sum_reg;
    logic [tbn_pkg::ROOT_W-1:0]    root_reg;

    // Result
    logic signed [OW-1:0]  res_t_reg [3];
    logic signed [OW-1:0]  res_b_reg [3];
    tbn_pkg::status_t      status_reg;

    // Vertex transaction decode
    logic take, is_third, take_first, take_second, take_third;
    logic signed [W-1:0] pin [3];

    // Unit interfaces
    logic                          xm_start, xm_done;
    logic signed [DW-1:0]          xa, xb, xc, xd;
    logic signed [RW-1:0]          xm_res;
    logic                          sq_start, sq_done;
    logic signed [tbn_pkg::SQ_AW-1:0] sq_op;
    logic signed [2*tbn_pkg::SQ_AW:0] sq_res;
    logic                          sr_start, sr_done;
    logic [tbn_pkg::ROOT_W-1:0]    sr_root;
    logic                          dv_start, dv_done;
    logic [NB-1:0]                 dv_numer;
    logic [QW-1:0]                 dv_quot;

    // Misc datapath
    logic [NW-1:0]        s_cur;
    logic [SW-1:0]        mag_or;
    logic                 mag_hi, mag_top;
    logic                 tr_zero, br_zero, flip;
    logic [XW-1:0]        q_ext;
    logic signed [OW-1:0] q_signed;

    assign pin[0] = pos_x;
    assign pin[1] = pos_y;
    assign pin[2] = pos_z;

    assign take        = start && (state_reg == tbn_pkg::S_IDLE);
    assign is_third    = !start_triangle && (vcnt_reg == 2'd2);
    assign take_first  = take && !is_third && (start_triangle || vcnt_reg != 2'd1);
    assign take_second = take && !start_triangle && (vcnt_reg == 2'd1);
    assign take_third  = take && is_third;

    assign busy = (state_reg != tbn_pkg::S_IDLE);

    // Operand select for the cross-difference unit
    always_comb
    begin
        xa = '0;
        xb = '0;
        xc = '0;
        xd = '0;
        unique case (op_reg)
            tbn_pkg::OP_DET: begin xa = du1_reg;   xb = dv2_reg;   xc = du2_reg;   xd = dv1_reg;   end
            tbn_pkg::OP_TX:  begin xa = dv2_reg;   xb = e1_reg[0]; xc = dv1_reg;   xd = e2_reg[0]; end
            tbn_pkg::OP_TY:  begin xa = dv2_reg;   xb = e1_reg[1]; xc = dv1_reg;   xd = e2_reg[1]; end
            tbn_pkg::OP_TZ:  begin xa = dv2_reg;   xb = e1_reg[2]; xc = dv1_reg;   xd = e2_reg[2]; end
            tbn_pkg::OP_BX:  begin xa = du1_reg;   xb = e2_reg[0]; xc = du2_reg;   xd = e1_reg[0]; end
            tbn_pkg::OP_BY:  begin xa = du1_reg;   xb = e2_reg[1]; xc = du2_reg;   xd = e1_reg[1]; end
            tbn_pkg::OP_BZ:  begin xa = du1_reg;   xb = e2_reg[2]; xc = du2_reg;   xd = e1_reg[2]; end
            tbn_pkg::OP_NX:  begin xa = e1_reg[1]; xb = e2_reg[2]; xc = e1_reg[2]; xd = e2_reg[1]; end
            tbn_pkg::OP_NY:  begin xa = e1_reg[2]; xb = e2_reg[0]; xc = e1_reg[0]; xd = e2_reg[2]; end
            tbn_pkg::OP_NZ:  begin xa = e1_reg[0]; xb = e2_reg[1]; xc = e1_reg[1]; xd = e2_reg[0]; end
            default:         begin xa = '0;        xb = '0;        xc = '0;        xd = '0;        end
        endcase
    end

    // Normaliser helpers
    always_comb
    begin
        mag_or   = mag_reg[0] | mag_reg[1] | mag_reg[2];
        mag_hi   = |mag_or[SW-1:NW];
        mag_top  = mag_or[NW-1];
        s_cur    = mag_reg[comp_reg][NW-1:0];
        sq_op    = {1'b0, s_cur};
        dv_numer = {1'b0, s_cur, {F{1'b0}}} + NB'(root_reg >> 1);
        tr_zero  = (tr_reg[0] == '0) && (tr_reg[1] == '0) && (tr_reg[2] == '0);
        br_zero  = (br_reg[0] == '0) && (br_reg[1] == '0) && (br_reg[2] == '0);
        flip     = det_neg_reg && !nz_reg;
        q_ext    = XW'(dv_quot);
        q_signed = (negc_reg[comp_reg] ^ flip) ? -$signed(q_ext[OW-1:0])
                                               : $signed(q_ext[OW-1:0]);
    end

    assign xm_start = (state_reg == tbn_pkg::S_XM_GO);
    assign sq_start = (state_reg == tbn_pkg::S_SQ_GO);
    assign sr_start = (state_reg == tbn_pkg::S_SR_GO);
    assign dv_start = (state_reg == tbn_pkg::S_DV_GO);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        vcnt_next  = vcnt_reg;
        vec_next   = vec_reg;
        comp_next  = comp_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            tbn_pkg::S_IDLE:
            begin
                if (take_first)
                    vcnt_next = 2'd1;
                else if (take_second)
                    vcnt_next = 2'd2;
                else if (take_third)
                begin
                    vcnt_next  = 2'd0;
                    op_next    = tbn_pkg::OP_DET;
                    state_next = tbn_pkg::S_XM_GO;
                end
            end
            tbn_pkg::S_XM_GO:
                state_next = tbn_pkg::S_XM_WAIT;
            tbn_pkg::S_XM_WAIT:
            begin
                if (xm_done)
                begin
                    if (op_reg == tbn_pkg::OP_NZ)
                        state_next = tbn_pkg::S_CHECK;
                    else
                    begin
                        op_next    = tbn_pkg::xop_t'(op_reg + 4'd1);
                        state_next = tbn_pkg::S_XM_GO;
                    end
                end
            end
            tbn_pkg::S_CHECK:
            begin
                if (det_zero_reg || tr_zero || br_zero)
                    state_next = tbn_pkg::S_FINISH;
                else
                begin
                    vec_next   = 1'b0;
                    state_next = tbn_pkg::S_NM_LOAD;
                end
            end
            tbn_pkg::S_NM_LOAD:
                state_next = tbn_pkg::S_NM_SHIFT;
            tbn_pkg::S_NM_SHIFT:
            begin
                if (!mag_hi && mag_top)
                begin
                    comp_next  = 2'd0;
                    state_next = tbn_pkg::S_SQ_GO;
                end
            end
            tbn_pkg::S_SQ_GO:
                state_next = tbn_pkg::S_SQ_WAIT;
            tbn_pkg::S_SQ_WAIT:
            begin
                if (sq_done)
                begin
                    if (comp_reg == 2'd2)
                    begin
                        comp_next  = 2'd0;
                        state_next = tbn_pkg::S_SR_GO;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = tbn_pkg::S_SQ_GO;
                    end
                end
            end
            tbn_pkg::S_SR_GO:
                state_next = tbn_pkg::S_SR_WAIT;
            tbn_pkg::S_SR_WAIT:
            begin
                if (sr_done)
                begin
                    comp_next  = 2'd0;
                    state_next = tbn_pkg::S_DV_GO;
                end
            end
            tbn_pkg::S_DV_GO:
                state_next = tbn_pkg::S_DV_WAIT;
            tbn_pkg::S_DV_WAIT:
            begin
                if (dv_done)
                begin
                    if (comp_reg == 2'd2)
                    begin
                        comp_next = 2'd0;
                        if (vec_reg)
                            state_next = tbn_pkg::S_FINISH;
                        else
                        begin
                            vec_next   = 1'b1;
                            state_next = tbn_pkg::S_NM_LOAD;
                        end
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = tbn_pkg::S_DV_GO;
                    end
                end
            end
            tbn_pkg::S_FINISH:
            begin
                done_next  = 1'b1;
                state_next = tbn_pkg::S_IDLE;
            end
            default:
                state_next = tbn_pkg::S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tbn_pkg::S_IDLE;
            op_reg    <= tbn_pkg::OP_DET;
            vcnt_reg  <= 2'd0;
            vec_reg   <= 1'b0;
            comp_reg  <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            vcnt_reg  <= vcnt_next;
            vec_reg   <= vec_next;
            comp_reg  <= comp_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        // vertex store
        if (take_first)
        begin
            for (int i = 0; i < 3; i++)
                fpos_reg[i] <= pin[i];
            fuv_reg[0] <= tex_u;
            fuv_reg[1] <= tex_v;
        end
        if (take_second)
        begin
            for (int i = 0; i < 3; i++)
                spos_reg[i] <= pin[i];
            suv_reg[0] <= tex_u;
            suv_reg[1] <= tex_v;
        end

        // edges and UV deltas of the triangle
        if (take_third)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i] <= DW'(spos_reg[i]) - DW'(fpos_reg[i]);
                e2_reg[i] <= DW'(pin[i]) - DW'(fpos_reg[i]);
            end
            du1_reg <= DW'(suv_reg[0]) - DW'(fuv_reg[0]);
            dv1_reg <= DW'(suv_reg[1]) - DW'(fuv_reg[1]);
            du2_reg <= DW'(tex_u) - DW'(fuv_reg[0]);
            dv2_reg <= DW'(tex_v) - DW'(fuv_reg[1]);
            nz_reg  <= 1'b0;
        end

        // collect cross differences
        if (state_reg == tbn_pkg::S_XM_WAIT && xm_done)
        begin
            unique case (op_reg)
                tbn_pkg::OP_DET:
                begin
                    det_zero_reg <= (xm_res == '0);
                    det_neg_reg  <= xm_res[RW-1];
                end
                tbn_pkg::OP_TX: tr_reg[0] <= xm_res;
                tbn_pkg::OP_TY: tr_reg[1] <= xm_res;
                tbn_pkg::OP_TZ: tr_reg[2] <= xm_res;
                tbn_pkg::OP_BX: br_reg[0] <= xm_res;
                tbn_pkg::OP_BY: br_reg[1] <= xm_res;
                tbn_pkg::OP_BZ: br_reg[2] <= xm_res;
                tbn_pkg::OP_NX,
                tbn_pkg::OP_NY,
                tbn_pkg::OP_NZ: nz_reg <= nz_reg | (xm_res != '0);
                default: ;
            endcase
        end

        // degenerate cases give zero vectors
        if (state_reg == tbn_pkg::S_CHECK)
        begin
            if (det_zero_reg)
                status_reg <= tbn_pkg::STAT_ZERO_DET;
            else if (tr_zero || br_zero)
                status_reg <= tbn_pkg::STAT_ZERO_LEN;
            else
                status_reg <= tbn_pkg::STAT_OK;
            if (det_zero_reg || tr_zero || br_zero)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    res_t_reg[i] <= '0;
                    res_b_reg[i] <= '0;
                end
            end
        end

        // load magnitudes of the vector in hand
        if (state_reg == tbn_pkg::S_NM_LOAD)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic signed [RW-1:0] raw;
                raw         = vec_reg ? br_reg[i] : tr_reg[i];
                negc_reg[i] <= raw[RW-1];
                mag_reg[i]  <= SW'(raw[RW-1] ? $unsigned(-raw) : $unsigned(raw));
            end
            sum_reg <= '0;
        end

        // scale so the largest magnitude sits in [2^29, 2^30)
        if (state_reg == tbn_pkg::S_NM_SHIFT)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (mag_hi)
                    mag_reg[i] <= mag_reg[i] >> 1;
                else if (!mag_top)
                    mag_reg[i] <= mag_reg[i] << 1;
            end
        end

        if (state_reg == tbn_pkg::S_SQ_WAIT && sq_done)
            sum_reg <= sum_reg + sq_res[tbn_pkg::SUM_W-1:0];

        if (state_reg == tbn_pkg::S_SR_WAIT && sr_done)
            root_reg <= sr_root;

        // rounded quotient with the component sign and handedness flip
        if (state_reg == tbn_pkg::S_DV_WAIT && dv_done)
        begin
            if (vec_reg)
                res_b_reg[comp_reg] <= q_signed;
            else
                res_t_reg[comp_reg] <= q_signed;
        end
    end

    // Serial units
    tbn_xmul #(.AW(DW)) u_xmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (xm_start),
        .a      (xa),
        .b      (xb),
        .c      (xc),
        .d      (xd),
        .done   (xm_done),
        .result (xm_res)
    );

    tbn_xmul #(.AW(tbn_pkg::SQ_AW)) u_sqr (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sq_start),
        .a      (sq_op),
        .b      (sq_op),
        .c      ('0),
        .d      ('0),
        .done   (sq_done),
        .result (sq_res)
    );

    tbn_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sr_start),
        .radicand (sum_reg),
        .done     (sr_done),
        .root     (sr_root)
    );

    tbn_div #(.NB(NB)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .numer (dv_numer),
        .denom (root_reg),
        .done  (dv_done),
        .quot  (dv_quot)
    );

    // Result ports
    assign done        = done_reg;
    assign tangent_x   = res_t_reg[0];
    assign tangent_y   = res_t_reg[1];
    assign tangent_z   = res_t_reg[2];
    assign bitangent_x = res_b_reg[0];
    assign bitangent_y = res_b_reg[1];
    assign bitangent_z = res_b_reg[2];
    assign status      = status_reg;

endmodule

// ----- rtl/core/tbn_checker.sv -----
// tbn_checker: port-level checks of the tangent frame block.
// Depends on tbn_pkg; bound to triangle_tangent_bitangent below.

module tbn_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic [tbn_pkg::OUT_W-1:0]         tangent_x,
    input logic [tbn_pkg::OUT_W-1:0]         tangent_y,
    input logic [tbn_pkg::OUT_W-1:0]         tangent_z,
    input logic [tbn_pkg::OUT_W-1:0]         bitangent_x,
    input logic [tbn_pkg::OUT_W-1:0]         bitangent_y,
    input logic [tbn_pkg::OUT_W-1:0]         bitangent_z,
    input logic [tbn_pkg::STAT_W-1:0]        status
);

    // One result per triangle: never two strobes back to back
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // A result closes a busy stretch
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without prior computation");

    // Work only starts from a vertex transaction
    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy raised without a vertex transaction");

    // Degenerate triangles give zero vectors
    a_zero_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == tbn_pkg::STAT_ZERO_DET || status == tbn_pkg::STAT_ZERO_LEN)
        |-> (tangent_x == '0 && tangent_y == '0 && tangent_z == '0 &&
             bitangent_x == '0 && bitangent_y == '0 && bitangent_z == '0))
        else $error("non-zero vector with a fault status");

endmodule

bind triangle_tangent_bitangent tbn_checker u_tbn_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .tangent_x   (tangent_x),
    .tangent_y   (tangent_y),
    .tangent_z   (tangent_z),
    .bitangent_x (bitangent_x),
    .bitangent_y (bitangent_y),
    .bitangent_z (bitangent_z),
    .status      (status)
);
